// ----- sv/jmfs_pkg.sv -----
// shared types and constants for the jpeg marker frame splitter
package jmfs_pkg;

  localparam logic [7:0] ByteFf   = 8'hff;
  localparam logic [7:0] ByteZero = 8'h00;
  localparam logic [7:0] MarkSoi  = 8'hd8;
  localparam logic [7:0] MarkEoi  = 8'hd9;
  localparam logic [7:0] MarkSos  = 8'hda;
  localparam logic [7:0] MarkRst0 = 8'hd0;
  localparam logic [7:0] MarkRst7 = 8'hd7;
  localparam logic [7:0] MarkSof2 = 8'hc2;

  // one classified word handed from the front to the back
  typedef struct packed {
    logic        head;       // header start: emit ff d8 ff
    logic        valid;      // one byte word
    logic [7:0]  data;
    logic        last;       // frame close
    logic        trunc;
    logic [15:0] width;
    logic [15:0] height;
    logic        interlaced;
    logic        yuv420;
    logic        herr;
    logic        sync;
  } cmd_t;

  function automatic logic is_sof(input logic [7:0] m);
    return (m[7:4] == 4'hc) && (m != 8'hc4) && (m != 8'hc8) && (m != 8'hcc);
  endfunction

endpackage

// ----- sv/jmfs_front.sv -----
// front part: header hunt, segment walk and frame property capture
module jmfs_front import jmfs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic [7:0] in_byte_i,
  input  logic       stream_end_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  typedef enum logic [7:0] {
    WOut  = 8'b00000001,
    WMark = 8'b00000010,
    WTag  = 8'b00000100,
    WLenH = 8'b00001000,
    WLenL = 8'b00010000,
    WPay  = 8'b00100000,
    WEnt  = 8'b01000000,
    WRes  = 8'b10000000
  } walk_e;

  walk_e walk_q, walk_d;
  logic [1:0] hunt_q, hunt_d;
  logic [7:0] mark_q, mark_d;
  logic [15:0] rem_q, rem_d, pos_q, pos_d, wid_q, wid_d, hgt_q, hgt_d;
  logic sawff_q, sawff_d;
  logic [7:0] ncomp_q, ncomp_d, samp0_q, samp0_d, samp1_q, samp1_d;
  logic inter_q, inter_d, herr_q, herr_d, sync_q, sync_d, sof_q, sof_d, sos_q, sos_d;

  logic [7:0] b;
  logic eoi, do_tag;
  logic [15:0] len;
  logic [15:0] rem_dec;
  logic [3:0] h0, v0, h1, v1;
  logic [7:0] p0, p1;
  logic yuv;

  assign b = in_byte_i;
  assign len = {rem_q[15:8], b};
  assign rem_dec = rem_q - 16'd1;

  // 4:2:0 test: p0/p1 == 4 means 4*p1 <= p0 < 5*p1
  always_comb begin
    h0 = samp0_q[7:4];
    v0 = samp0_q[3:0];
    h1 = samp1_q[7:4];
    v1 = samp1_q[3:0];
    p0 = {4'b0, h0} * {4'b0, v0};
    p1 = {4'b0, h1} * {4'b0, v1};
    yuv = (ncomp_q == 8'd3) && (p1 != 8'd0) && (h0 == 4'd2) &&
          ({2'b0, p1, 2'b0} <= {4'b0, p0}) &&
          ({4'b0, p0} < ({2'b0, p1, 2'b0} + {4'b0, p1}));
  end

  always_comb begin
    walk_d = walk_q; hunt_d = hunt_q; mark_d = mark_q; rem_d = rem_q; pos_d = pos_q;
    wid_d = wid_q; hgt_d = hgt_q; sawff_d = sawff_q; ncomp_d = ncomp_q;
    samp0_d = samp0_q; samp1_d = samp1_q;
    inter_d = inter_q; herr_d = herr_q; sync_d = sync_q; sof_d = sof_q; sos_d = sos_q;
    eoi = 1'b0; do_tag = 1'b0;
    push_o = 1'b0;
    cmd_o = '0;
    if (en_i) begin
      if (stream_end_i) begin
        hunt_d = 2'd0;
        if (walk_q != WOut) begin
          push_o = 1'b1;
          cmd_o.last = 1'b1;
          cmd_o.trunc = 1'b1;
          cmd_o.width = wid_q;
          cmd_o.height = hgt_q;
          cmd_o.interlaced = inter_q;
          cmd_o.yuv420 = yuv;
          cmd_o.herr = herr_q | ~sof_q;
          cmd_o.sync = sync_q;
          walk_d = WOut; sawff_d = 1'b0; rem_d = '0; pos_d = '0;
          herr_d = herr_q | ~sof_q;
        end
      end else if (walk_q == WOut) begin
        if (hunt_q == 2'd2 && b == ByteFf) begin
          {inter_d, herr_d, sync_d, sof_d, sos_d} = '0;
          wid_d = '0; hgt_d = '0; ncomp_d = '0; samp0_d = '0; samp1_d = '0;
          mark_d = '0; hunt_d = 2'd0; walk_d = WTag;
          push_o = 1'b1;
          cmd_o.head = 1'b1;
        end else if (b == ByteFf) hunt_d = 2'd1;
        else if (hunt_q == 2'd1 && b == MarkSoi) hunt_d = 2'd2;
        else hunt_d = 2'd0;
      end else begin
        push_o = 1'b1;
        cmd_o.valid = 1'b1;
        cmd_o.data = b;
        unique case (walk_q)
          WMark: begin
            if (b == ByteFf) walk_d = WTag;
            else begin
              sync_d = 1'b1; walk_d = WRes;
            end
          end
          WRes: if (b == ByteFf) walk_d = WTag;
          WTag: do_tag = 1'b1;
          WLenH: begin
            rem_d = {b, 8'h00}; walk_d = WLenL;
          end
          WLenL: begin
            if (len < 16'd2) begin
              herr_d = 1'b1; sync_d = 1'b1; rem_d = '0; walk_d = WRes;
            end else begin
              rem_d = len - 16'd2; pos_d = '0;
              if (len == 16'd2) begin
                if (mark_q == MarkSos) begin
                  sawff_d = 1'b0; walk_d = WEnt;
                end else walk_d = WMark;
              end else walk_d = WPay;
            end
          end
          WPay: begin
            if (is_sof(mark_q) && !sos_q) begin
              case (pos_q)
                16'd1: hgt_d[15:8] = b;
                16'd2: hgt_d[7:0] = b;
                16'd3: wid_d[15:8] = b;
                16'd4: wid_d[7:0] = b;
                16'd5: ncomp_d = b;
                16'd7: samp0_d = b;
                16'd10: samp1_d = b;
                default: ;
              endcase
            end
            if (pos_q != 16'hffff) pos_d = pos_q + 16'd1;
            rem_d = rem_dec;
            if (rem_dec == 16'd0) begin
              if (mark_q == MarkSos) begin
                sawff_d = 1'b0; walk_d = WEnt;
              end else walk_d = WMark;
            end
          end
          WEnt: begin
            if (sawff_q) begin
              sawff_d = 1'b0;
              if (b != ByteZero) begin
                walk_d = WTag; do_tag = 1'b1;
              end
            end else if (b == ByteFf) sawff_d = 1'b1;
          end
          default: walk_d = WRes;
        endcase
        if (do_tag && b != ByteFf) begin
          if (b == MarkEoi) begin
            eoi = 1'b1;
          end else begin
            mark_d = b;
            if (b >= MarkRst0 && b <= MarkRst7) begin
              sawff_d = 1'b0; walk_d = WEnt;
            end else if (b == MarkSoi) walk_d = WMark;
            else begin
              if (b == MarkSos) sos_d = 1'b1;
              if (is_sof(b) && !sos_q) begin
                sof_d = 1'b1;
                if (b == MarkSof2) inter_d = 1'b1;
                wid_d = '0; hgt_d = '0; ncomp_d = '0; samp0_d = '0; samp1_d = '0;
              end
              walk_d = WLenH;
            end
          end
        end
        if (eoi) begin
          cmd_o.last = 1'b1;
          cmd_o.width = wid_q;
          cmd_o.height = hgt_q;
          cmd_o.interlaced = inter_q;
          cmd_o.yuv420 = yuv;
          cmd_o.herr = herr_q | ~sos_q | ~sof_q;
          cmd_o.sync = sync_q;
          herr_d = herr_q | ~sos_q | ~sof_q;
          walk_d = WOut; hunt_d = 2'd0; sawff_d = 1'b0; rem_d = '0; pos_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q <= WOut; hunt_q <= '0; mark_q <= '0; rem_q <= '0; pos_q <= '0;
      wid_q <= '0; hgt_q <= '0; sawff_q <= 1'b0; ncomp_q <= '0;
      samp0_q <= '0; samp1_q <= '0;
      inter_q <= 1'b0; herr_q <= 1'b0; sync_q <= 1'b0; sof_q <= 1'b0; sos_q <= 1'b0;
    end else begin
      walk_q <= walk_d; hunt_q <= hunt_d; mark_q <= mark_d; rem_q <= rem_d; pos_q <= pos_d;
      wid_q <= wid_d; hgt_q <= hgt_d; sawff_q <= sawff_d; ncomp_q <= ncomp_d;
      samp0_q <= samp0_d; samp1_q <= samp1_d;
      inter_q <= inter_d; herr_q <= herr_d; sync_q <= sync_d; sof_q <= sof_d; sos_q <= sos_d;
    end
  end

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(walk_q))
    else $error("walk state not one-hot");
  a_head_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && cmd_o.head |-> walk_q == WOut)
    else $error("header start inside a frame");
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && push_o && cmd_o.last |=> walk_q == WOut)
    else $error("frame close left walk open");

endmodule

// ----- sv/jmfs_back.sv -----
// back part: queue of classified words and expansion into result words
module jmfs_back import jmfs_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  cmd_t        cmd_i,
  output logic        space_o,
  output logic        valid_o,
  input  logic        ready_i,
  output logic        byte_valid_o,
  output logic [7:0]  out_byte_o,
  output logic        frame_first_o,
  output logic        frame_last_o,
  output logic [15:0] image_width_o,
  output logic [15:0] image_height_o,
  output logic        is_interlaced_o,
  output logic        is_yuv420_o,
  output logic        header_error_o,
  output logic        sync_lost_o,
  output logic        truncated_o
);

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  cmd_t mem_q [Depth];
  logic [Aw-1:0] wr_q, rd_q;
  logic [Aw:0] cnt_q;
  logic [1:0] sub_q;  // position within a header start word
  cmd_t head;
  logic pop;

  assign head = mem_q[rd_q];
  assign valid_o = cnt_q != '0;
  // one spare entry covers the word in flight from the front
  assign space_o = cnt_q < (Aw+1)'(Depth - 1);
  assign pop = valid_o && ready_i && (!head.head || sub_q == 2'd2);

  always_comb begin
    byte_valid_o = 1'b1;
    out_byte_o = ByteFf;
    frame_first_o = 1'b0;
    frame_last_o = 1'b0;
    image_width_o = '0;
    image_height_o = '0;
    is_interlaced_o = 1'b0;
    is_yuv420_o = 1'b0;
    header_error_o = 1'b0;
    sync_lost_o = 1'b0;
    truncated_o = 1'b0;
    if (head.head) begin
      frame_first_o = sub_q == 2'd0;
      if (sub_q == 2'd1) out_byte_o = MarkSoi;
    end else begin
      byte_valid_o = head.valid;
      out_byte_o = head.data;
      frame_last_o = head.last;
      image_width_o = head.width;
      image_height_o = head.height;
      is_interlaced_o = head.interlaced;
      is_yuv420_o = head.yuv420;
      header_error_o = head.herr;
      sync_lost_o = head.sync;
      truncated_o = head.trunc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0; sub_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == Aw'(Depth - 1)) ? '0 : wr_q + Aw'(1);
      if (pop) rd_q <= (rd_q == Aw'(Depth - 1)) ? '0 : rd_q + Aw'(1);
      cnt_q <= cnt_q + (Aw+1)'(push_i) - (Aw+1)'(pop);
      if (pop) sub_q <= '0;
      else if (valid_o && ready_i) sub_q <= sub_q + 2'd1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> cnt_q < (Aw+1)'(Depth) || pop)
    else $error("queue overflow");
  a_sub_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q != 2'd0 |-> valid_o && head.head)
    else $error("header position without header word");
  a_sub_range: assert property (@(posedge clk_i) disable iff (!rst_ni) sub_q != 2'd3)
    else $error("header position out of range");

endmodule

// ----- sv/jpeg_marker_frame_splitter.sv -----
// jpeg marker frame splitter top level
// path: a taken byte passes the pipeline register and then a queue entry before it leaves
// throughput: one byte word per cycle while the queue has space; a header start yields three words in turn
// the rate is set by the front walk register, one byte per cycle while the queue has space
// reset: asynchronous active low, clears the walk and hunt state and the queue
module jpeg_marker_frame_splitter import jmfs_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        stream_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        byte_valid_o,
  output logic [7:0]  out_byte_o,
  output logic        frame_first_o,
  output logic        frame_last_o,
  output logic [15:0] image_width_o,
  output logic [15:0] image_height_o,
  output logic        is_interlaced_o,
  output logic        is_yuv420_o,
  output logic        header_error_o,
  output logic        sync_lost_o,
  output logic        truncated_o
);

  // classified word from the front, registered before entering the queue
  cmd_t cmd_w, cmd_q;
  logic push_w, push_q;
  logic space;
  logic take;

  // the queue keeps one entry spare for the registered word in flight
  assign in_ready_o = space;
  assign take = in_valid_i && in_ready_o;

  jmfs_front u_front (
    .clk_i,
    .rst_ni,
    .en_i         (take),
    .in_byte_i,
    .stream_end_i,
    .push_o       (push_w),
    .cmd_o        (cmd_w)
  );

  // pipeline register between front and queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push_q <= 1'b0;
    end else begin
      push_q <= push_w;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_w;
  end

  jmfs_back #(.Depth(QueueDepth + 1)) u_back (
    .clk_i,
    .rst_ni,
    .push_i          (push_q),
    .cmd_i           (cmd_q),
    .space_o         (space),
    .valid_o         (out_valid_o),
    .ready_i         (out_ready_i),
    .byte_valid_o,
    .out_byte_o,
    .frame_first_o,
    .frame_last_o,
    .image_width_o,
    .image_height_o,
    .is_interlaced_o,
    .is_yuv420_o,
    .header_error_o,
    .sync_lost_o,
    .truncated_o
  );

  a_first_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_first_o |-> byte_valid_o && out_byte_o == ByteFf)
    else $error("frame start word is not ff");
  a_trunc_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && truncated_o |-> frame_last_o && !byte_valid_o)
    else $error("truncated word malformed");
  a_push_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_w |-> take)
    else $error("front word without input");

endmodule

// ----- tb/sv/tb_jpeg_marker_frame_splitter.sv -----
// self-checking testbench for the jpeg marker frame splitter
module tb_jpeg_marker_frame_splitter;
  import jmfs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned RandomWords = 280;

  // walk phases of the frame walker
  typedef enum logic [3:0] {
    WalkOut, WalkMarkFf, WalkTag, WalkLenHi, WalkLenLo, WalkPayload, WalkEntropy,
    WalkResync
  } walk_e;

  typedef struct {
    logic        byte_valid;
    logic [7:0]  out_byte;
    logic        first;
    logic        last;
    logic [15:0] width;
    logic [15:0] height;
    logic        interlaced;
    logic        yuv420;
    logic        herr;
    logic        sync;
    logic        trunc;
  } frame_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  in_byte_i;
  logic        stream_end_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        byte_valid_o;
  logic [7:0]  out_byte_o;
  logic        frame_first_o;
  logic        frame_last_o;
  logic [15:0] image_width_o;
  logic [15:0] image_height_o;
  logic        is_interlaced_o;
  logic        is_yuv420_o;
  logic        header_error_o;
  logic        sync_lost_o;
  logic        truncated_o;

  frame_word_t expected_words[$];
  int unsigned err_count;
  int unsigned cycle_count;
  int unsigned words_sent;
  bit          hold_request;

  // predictor state
  logic [1:0]  hunt_st;
  walk_e       walk_st;
  logic [7:0]  cur_mark;
  logic [15:0] seg_left;
  logic [15:0] seg_pos;
  logic        ent_ff;
  logic [15:0] wid_r;
  logic [15:0] hgt_r;
  logic [7:0]  ncomp;
  logic [7:0]  samp0;
  logic [7:0]  samp1;
  logic        f_inter, f_herr, f_sync, f_sof, f_sos;

  jpeg_marker_frame_splitter i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_byte_i       (in_byte_i),
    .stream_end_i    (stream_end_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .byte_valid_o    (byte_valid_o),
    .out_byte_o      (out_byte_o),
    .frame_first_o   (frame_first_o),
    .frame_last_o    (frame_last_o),
    .image_width_o   (image_width_o),
    .image_height_o  (image_height_o),
    .is_interlaced_o (is_interlaced_o),
    .is_yuv420_o     (is_yuv420_o),
    .header_error_o  (header_error_o),
    .sync_lost_o     (sync_lost_o),
    .truncated_o     (truncated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // watchdog: a hung handshake ends the run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic sof_marker(input logic [7:0] m);
    return (m[7:4] == 4'hc) && (m != 8'hc4) && (m != 8'hc8) && (m != 8'hcc);
  endfunction

  // 4:2:0 test from the sampling bytes; a zero divisor means not 4:2:0
  function automatic logic yuv420_now();
    int unsigned h0, v0, h1, v1, d;
    h0 = samp0[7:4];
    v0 = samp0[3:0];
    h1 = samp1[7:4];
    v1 = samp1[3:0];
    d = h1 * v1;
    if (ncomp != 8'd3 || d == 0) return 1'b0;
    return ((h0 * v0) / d == 4) && (h0 == 2);
  endfunction

  function automatic void push_word(input logic bv, input logic [7:0] b, input logic first,
                                    input logic last, input logic trunc);
    frame_word_t w;
    w = '{default: '0};
    w.byte_valid = bv;
    w.out_byte = b;
    w.first = first;
    w.last = last;
    if (last) begin
      w.width = wid_r;
      w.height = hgt_r;
      w.interlaced = f_inter;
      w.yuv420 = yuv420_now();
      w.herr = f_herr;
      w.sync = f_sync;
      w.trunc = trunc;
    end
    expected_words.push_back(w);
  endfunction

  function automatic void clear_capture();
    wid_r = '0;
    hgt_r = '0;
    ncomp = '0;
    samp0 = '0;
    samp1 = '0;
  endfunction

  function automatic void end_of_segment();
    if (cur_mark == MarkSos) begin
      ent_ff = 1'b0;
      walk_st = WalkEntropy;
    end else begin
      walk_st = WalkMarkFf;
    end
  endfunction

  // byte in marker tag position; returns 1 on eoi
  function automatic logic marker_tag(input logic [7:0] b);
    if (b == ByteFf) return 1'b0;
    if (b == MarkEoi) begin
      if (!f_sos) f_herr = 1'b1;
      return 1'b1;
    end
    cur_mark = b;
    if (b >= MarkRst0 && b <= MarkRst7) begin
      ent_ff = 1'b0;
      walk_st = WalkEntropy;
      return 1'b0;
    end
    if (b == MarkSoi) begin
      walk_st = WalkMarkFf;
      return 1'b0;
    end
    if (b == MarkSos) f_sos = 1'b1;
    if (sof_marker(b) && !f_sos) begin
      f_sof = 1'b1;
      if (b == MarkSof2) f_inter = 1'b1;
      clear_capture();
    end
    walk_st = WalkLenHi;
    return 1'b0;
  endfunction

  function automatic void close_frame();
    walk_st = WalkOut;
    hunt_st = 2'd0;
    ent_ff = 1'b0;
    seg_left = '0;
    seg_pos = '0;
  endfunction

  // works out the frame words caused by one accepted input word
  function automatic void predict_word(input logic [7:0] b, input logic se);
    logic eoi;
    logic [15:0] len;
    eoi = 1'b0;
    if (se) begin
      if (walk_st == WalkOut) begin
        hunt_st = 2'd0;
        return;
      end
      if (!f_sof) f_herr = 1'b1;
      push_word(1'b0, 8'h00, 1'b0, 1'b1, 1'b1);
      close_frame();
      return;
    end
    if (walk_st == WalkOut) begin
      if (hunt_st == 2'd2 && b == ByteFf) begin
        {f_inter, f_herr, f_sync, f_sof, f_sos} = '0;
        clear_capture();
        cur_mark = '0;
        hunt_st = 2'd0;
        walk_st = WalkTag;
        push_word(1'b1, ByteFf, 1'b1, 1'b0, 1'b0);
        push_word(1'b1, MarkSoi, 1'b0, 1'b0, 1'b0);
        push_word(1'b1, ByteFf, 1'b0, 1'b0, 1'b0);
        return;
      end
      if (b == ByteFf) hunt_st = 2'd1;
      else if (hunt_st == 2'd1 && b == MarkSoi) hunt_st = 2'd2;
      else hunt_st = 2'd0;
      return;
    end
    case (walk_st)
      WalkMarkFf: begin
        if (b == ByteFf) walk_st = WalkTag;
        else begin
          f_sync = 1'b1;
          walk_st = WalkResync;
        end
      end
      WalkResync: if (b == ByteFf) walk_st = WalkTag;
      WalkTag: eoi = marker_tag(b);
      WalkLenHi: begin
        seg_left = {b, 8'h00};
        walk_st = WalkLenLo;
      end
      WalkLenLo: begin
        len = seg_left | {8'h00, b};
        if (len < 16'd2) begin
          f_herr = 1'b1;
          f_sync = 1'b1;
          seg_left = '0;
          walk_st = WalkResync;
        end else begin
          seg_left = len - 16'd2;
          seg_pos = '0;
          if (seg_left == 16'd0) end_of_segment();
          else walk_st = WalkPayload;
        end
      end
      WalkPayload: begin
        if (sof_marker(cur_mark) && !f_sos) begin
          case (seg_pos)
            16'd1: hgt_r[15:8] = b;
            16'd2: hgt_r[7:0] = b;
            16'd3: wid_r[15:8] = b;
            16'd4: wid_r[7:0] = b;
            16'd5: ncomp = b;
            16'd7: samp0 = b;
            16'd10: samp1 = b;
            default: ;
          endcase
        end
        if (seg_pos != 16'hffff) seg_pos = seg_pos + 16'd1;
        seg_left = seg_left - 16'd1;
        if (seg_left == 16'd0) end_of_segment();
      end
      WalkEntropy: begin
        if (ent_ff) begin
          ent_ff = 1'b0;
          if (b != ByteZero) begin
            walk_st = WalkTag;
            eoi = marker_tag(b);
          end
        end else if (b == ByteFf) begin
          ent_ff = 1'b1;
        end
      end
      default: walk_st = WalkResync;
    endcase
    if (eoi) begin
      if (!f_sof) f_herr = 1'b1;
      push_word(1'b1, b, 1'b0, 1'b1, 1'b0);
      close_frame();
      return;
    end
    push_word(1'b1, b, 1'b0, 1'b0, 1'b0);
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // sends one word, predicting its results once it is taken
  task automatic send_word(input logic [7:0] b, input logic se = 1'b0);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i <= b;
    stream_end_i <= se;
    do @(posedge clk_i); while (!in_ready_o);
    predict_word(b, se);
    words_sent++;
  endtask

  task automatic send_bytes(input logic [7:0] bytes[$]);
    foreach (bytes[i]) send_word(bytes[i]);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned stall;
    hold_left = 0;
    stall = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else begin
        stall = pick_gap();
        out_ready_i <= (stall == 0);
      end
    end
  end

  // compares each taken frame word with the oldest expectation
  always @(posedge clk_i) begin
    frame_word_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        $error("frame word with nothing expected, out_byte %02h", out_byte_o);
        err_count++;
      end else begin
        w = expected_words.pop_front();
        if (byte_valid_o !== w.byte_valid) begin
          $error("byte_valid exp %0d got %0d", w.byte_valid, byte_valid_o); err_count++;
        end
        if (out_byte_o !== w.out_byte) begin
          $error("out_byte exp %02h got %02h", w.out_byte, out_byte_o); err_count++;
        end
        if (frame_first_o !== w.first) begin
          $error("frame_first exp %0d got %0d", w.first, frame_first_o); err_count++;
        end
        if (frame_last_o !== w.last) begin
          $error("frame_last exp %0d got %0d", w.last, frame_last_o); err_count++;
        end
        if (image_width_o !== w.width) begin
          $error("image_width exp %0d got %0d", w.width, image_width_o); err_count++;
        end
        if (image_height_o !== w.height) begin
          $error("image_height exp %0d got %0d", w.height, image_height_o); err_count++;
        end
        if (is_interlaced_o !== w.interlaced) begin
          $error("is_interlaced exp %0d got %0d", w.interlaced, is_interlaced_o);
          err_count++;
        end
        if (is_yuv420_o !== w.yuv420) begin
          $error("is_yuv420 exp %0d got %0d", w.yuv420, is_yuv420_o); err_count++;
        end
        if (header_error_o !== w.herr) begin
          $error("header_error exp %0d got %0d", w.herr, header_error_o); err_count++;
        end
        if (sync_lost_o !== w.sync) begin
          $error("sync_lost exp %0d got %0d", w.sync, sync_lost_o); err_count++;
        end
        if (truncated_o !== w.trunc) begin
          $error("truncated exp %0d got %0d", w.trunc, truncated_o); err_count++;
        end
      end
    end
  end

  // directed frames: yuv420 baseline with fill, stuffing and restart; progressive
  // frame; eoi before sos; short length; missing ff; stream end in and out of frame
  task automatic test_directed();
    send_bytes('{8'h00, 8'hff, 8'hd8, 8'hff, 8'hc0, 8'h00, 8'h0d, 8'h08, 8'hff, 8'hff,
                 8'h00, 8'h01, 8'h03, 8'h01, 8'h22, 8'h00, 8'h02, 8'h11, 8'hff, 8'hff,
                 8'hda, 8'h00, 8'h02, 8'h7f, 8'hff, 8'h00, 8'h80, 8'hff, 8'hd3, 8'h55,
                 8'hff, 8'hd9});
    send_bytes('{8'hff, 8'hd8, 8'hff, 8'hc2, 8'h00, 8'h06, 8'h08, 8'h00, 8'h10, 8'h00,
                 8'hff, 8'hd8, 8'hff, 8'hd9});
    send_bytes('{8'hff, 8'hd8, 8'hff, 8'he1, 8'h00, 8'h01, 8'h12, 8'hff, 8'hd9});
    send_bytes('{8'hff, 8'hd8, 8'hff, 8'hdb, 8'h00, 8'h02, 8'h42, 8'hff, 8'hda});
    send_word(8'h00, 1'b1);
    send_bytes('{8'hff, 8'hd8});
    send_word(8'hff, 1'b1);
  endtask

  task automatic send_segment(input logic [7:0] mark, input int unsigned plen);
    logic [15:0] len;
    len = 16'(plen + 2);
    send_word(ByteFf);
    if ($urandom_range(0, 4) == 0) send_word(ByteFf);
    send_word(mark);
    send_word(len[15:8]);
    send_word(len[7:0]);
    for (int unsigned i = 0; i < plen; i++) begin
      if (sof_marker(mark) && i == 5)
        send_word($urandom_range(0, 3) != 0 ? 8'd3 : 8'($urandom));
      else if (sof_marker(mark) && i == 7)
        send_word($urandom_range(0, 1) ? 8'h22 : {4'($urandom_range(0, 3)), 4'($urandom)});
      else if (sof_marker(mark) && i == 10)
        send_word($urandom_range(0, 1) ? 8'h11 : {4'($urandom_range(0, 2)), 4'($urandom)});
      else send_word(8'($urandom));
    end
  endtask

  // a well-formed frame with random content, sometimes broken or cut short
  task automatic send_random_frame();
    logic [7:0] m;
    int unsigned nseg;
    int unsigned r;
    repeat ($urandom_range(0, 2)) send_word(8'($urandom));
    send_bytes('{8'hff, 8'hd8, 8'hff});
    nseg = $urandom_range(1, 3);
    for (int unsigned s = 0; s < nseg; s++) begin
      r = $urandom_range(0, 9);
      if (r < 5) begin
        do m = 8'hc0 | 8'($urandom_range(0, 15)); while (!sof_marker(m));
        send_segment(m, $urandom_range(0, 5) == 0 ? $urandom_range(0, 10) : 11);
      end else if (r < 8) begin
        send_segment(8'he0 | 8'($urandom_range(0, 15)), $urandom_range(0, 4));
      end else if (r == 8) begin
        send_word(8'($urandom_range(0, 254)));
        send_word(8'($urandom_range(0, 254)));
      end else begin
        send_bytes('{8'hff, 8'hc4, 8'h00, 8'($urandom_range(0, 1))});
      end
    end
    send_segment(MarkSos, $urandom_range(0, 3));
    repeat ($urandom_range(2, 10)) begin
      r = $urandom_range(0, 9);
      if (r == 0) send_bytes('{8'hff, 8'h00});
      else if (r == 1) send_bytes('{8'hff, 8'(MarkRst0 + $urandom_range(0, 7))});
      else send_word(8'($urandom_range(0, 254)));
    end
    if ($urandom_range(0, 7) == 0) send_word(8'h00, 1'b1);
    else send_bytes('{8'hff, 8'hd9});
    if ($urandom_range(0, 9) == 0) send_word(8'($urandom), 1'b1);
  endtask

  task automatic test_random_frames();
    int unsigned start;
    start = words_sent;
    while (words_sent - start < RandomWords) begin
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 6)) send_word(8'($urandom));
      else send_random_frame();
    end
  endtask

  // receiver holds off long while frames keep coming, so the block must stall
  task automatic test_backpressure();
    hold_request = 1'b1;
    repeat (3) send_random_frame();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i <= 1'b0;
    in_byte_i <= '0;
    stream_end_i <= 1'b0;
    err_count = 0;
    cycle_count = 0;
    words_sent = 0;
    hold_request = 1'b0;
    hunt_st = '0;
    walk_st = WalkOut;
    cur_mark = '0;
    seg_left = '0;
    seg_pos = '0;
    ent_ff = 1'b0;
    clear_capture();
    {f_inter, f_herr, f_sync, f_sof, f_sos} = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random_frames();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
